### hw/rtl/flash_line_write_packer_core_defines.svh
// Assertion macros shared by the flash line write packer RTL.
`ifndef FLASH_LINE_WRITE_PACKER_CORE_DEFINES_SVH
`define FLASH_LINE_WRITE_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FLPK_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flpk assertion failed");

// Next-cycle implication, disabled during reset.
`define FLPK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flpk assertion failed");

`endif

### hw/rtl/flpk_pkg.sv
// Shared constants and types of the flash line write packer.
`timescale 1ns / 1ps
package flpk_pkg;

   localparam int DATA_W          = 8;
   localparam int OFFSET_W        = 17;
   localparam int LINE_BYTES      = 16;
   localparam int LINE_IDX_W      = 4;
   localparam int RAW_LINE_W      = OFFSET_W - LINE_IDX_W;
   localparam int LINE_ADDR_W     = 13;
   localparam int WORD_W          = 32;
   localparam int WORD_IDX_W      = 2;
   localparam int FLASH_PAGES_DEF = 128;
   localparam int PAGE_BYTES_DEF  = 1024;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [DATA_W-1:0] BYTE_PAD = 8'hFF;

   // One finished line on its way to the word emitter.
   typedef struct packed {
      logic [LINE_BYTES*DATA_W-1:0] line_data;
      logic [LINE_ADDR_W-1:0]       line_addr;
      logic                         wrapped;
      logic                         final_line;
   } line_entry_type;

endpackage

### hw/rtl/flpk_if.sv
// Byte request and word response channel interfaces.
`timescale 1ns / 1ps
interface flpk_req_if;
   logic                          valid;
   logic                          ready;
   logic [flpk_pkg::DATA_W-1:0]   data_byte;
   logic [flpk_pkg::OFFSET_W-1:0] start_offset;
   logic                          first_byte;
   logic                          last_byte;

   modport source (output valid, data_byte, start_offset, first_byte, last_byte,
                   input ready);
   modport sink   (input valid, data_byte, start_offset, first_byte, last_byte,
                   output ready);
endinterface

interface flpk_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [flpk_pkg::OFFSET_W-1:0] word_address;
   logic [flpk_pkg::WORD_W-1:0]   word_data;
   logic                          line_end;
   logic                          write_end;
   logic                          address_overflow;

   modport source (output valid, word_address, word_data, line_end, write_end,
                   address_overflow, input ready);
   modport sink   (input valid, word_address, word_data, line_end, write_end,
                   address_overflow, output ready);
endinterface

### hw/rtl/flpk_front.sv
// Front end: accepts bytes, assembles 16-byte lines, tracks line number and wrap.
`timescale 1ns / 1ps
module flpk_front #(
   parameter int FLASH_PAGES = flpk_pkg::FLASH_PAGES_DEF,
   parameter int PAGE_BYTES  = flpk_pkg::PAGE_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [flpk_pkg::DATA_W-1:0]   data_byte,
   input  logic [flpk_pkg::OFFSET_W-1:0] start_offset,
   input  logic                          first_byte,
   input  logic                          last_byte,
   output logic                          push_valid,
   input  logic                          push_ready,
   output flpk_pkg::line_entry_type      push_entry
);
   import flpk_pkg::*;

   localparam int LINE_COUNT = FLASH_PAGES * PAGE_BYTES / LINE_BYTES;
   localparam int LINE_W     = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
   localparam logic [LINE_W-1:0]  LINE_LAST = LINE_W'(LINE_COUNT - 1);
   localparam logic [31:0]        LINE_COUNT_32 = 32'(LINE_COUNT);
   // floor(2^RAW_LINE_W / line count): quotient estimate is exact or one low
   localparam logic [31:0]        RECIP_MUL = 32'((1 << RAW_LINE_W) / LINE_COUNT);

   logic [DATA_W-1:0]     line_ff [LINE_BYTES];
   logic [DATA_W-1:0]     line_in [LINE_BYTES];
   logic [LINE_IDX_W-1:0] fill_ff, fill_in;
   logic [LINE_W-1:0]     lnum_ff, lnum_in;
   logic                  wrapped_ff, wrapped_in;
   logic                  pend_ff, pend_in;
   logic                  final_ff, final_in;
   logic                  red_ff, red_in;
   logic                  step_ff, step_in;
   logic [RAW_LINE_W-1:0] rem_ff, rem_in;
   logic [RAW_LINE_W-1:0] quo_ff, quo_in;

   logic                  accept;
   logic                  push_fire;
   logic [LINE_IDX_W:0]   fill_next;
   logic [LINE_IDX_W-1:0] fill_base;
   logic [RAW_LINE_W-1:0] raw_line;
   logic                  raw_over;
   logic [31:0]           raw_32;
   logic [31:0]           quo_32;
   logic [31:0]           rem_32;
   logic [31:0]           prod_32;
   logic [RAW_LINE_W-1:0] rem_sub;
   logic [31:0]           rem_fix_32;

   assign push_fire  = pend_ff && !red_ff && push_ready;
   assign push_valid = pend_ff && !red_ff;
   assign in_ready   = !red_ff && (!pend_ff || push_ready);
   assign accept     = in_valid && in_ready;

   assign raw_line = start_offset[OFFSET_W-1:LINE_IDX_W];
   assign raw_32   = 32'(raw_line);
   assign raw_over = raw_32 >= LINE_COUNT_32;

   // Start line reduction: reciprocal quotient estimate at accept,
   // then subtract quotient times line count, then one correcting subtract
   assign quo_32     = (raw_32 * RECIP_MUL) >> RAW_LINE_W;
   assign rem_32     = 32'(rem_ff);
   assign prod_32    = 32'(quo_ff) * LINE_COUNT_32;
   assign rem_sub    = RAW_LINE_W'(rem_32 - prod_32);
   assign rem_fix_32 = (rem_32 >= LINE_COUNT_32) ? rem_32 - LINE_COUNT_32 : rem_32;

   // Outgoing line
   always_comb begin
      for (int i = 0; i < LINE_BYTES; i++) begin
         push_entry.line_data[i*DATA_W +: DATA_W] = line_ff[i];
      end
      push_entry.line_addr  = LINE_ADDR_W'(32'(lnum_ff));
      push_entry.wrapped    = wrapped_ff;
      push_entry.final_line = final_ff;
   end

   // Next state: line handoff, reduction step, then the accepted byte on top
   always_comb begin
      line_in    = line_ff;
      fill_in    = fill_ff;
      lnum_in    = lnum_ff;
      wrapped_in = wrapped_ff;
      pend_in    = pend_ff;
      final_in   = final_ff;
      red_in     = red_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      fill_base  = fill_ff;
      fill_next  = '0;

      if (push_fire) begin
         for (int i = 0; i < LINE_BYTES; i++) begin
            line_in[i] = BYTE_PAD;
         end
         fill_in = '0;
         pend_in = 1'b0;
         if (lnum_ff == LINE_LAST) begin
            lnum_in    = '0;
            wrapped_in = 1'b1;
         end else begin
            lnum_in = lnum_ff + 1'b1;
         end
      end

      if (red_ff) begin
         if (step_ff) begin
            rem_in  = rem_sub;
            step_in = 1'b0;
         end else begin
            red_in  = 1'b0;
            lnum_in = LINE_W'(rem_fix_32);
         end
      end

      if (accept) begin
         if (first_byte) begin
            for (int i = 0; i < LINE_BYTES; i++) begin
               line_in[i] = BYTE_PAD;
            end
            fill_in    = start_offset[LINE_IDX_W-1:0];
            wrapped_in = raw_over;
            if (raw_over) begin
               red_in  = 1'b1;
               step_in = 1'b1;
               rem_in  = raw_line;
               quo_in  = RAW_LINE_W'(quo_32);
            end else begin
               lnum_in = LINE_W'(raw_32);
            end
         end
         fill_base          = fill_in;
         line_in[fill_base] = data_byte;
         fill_next          = {1'b0, fill_base} + 1'b1;
         fill_in            = fill_next[LINE_IDX_W-1:0];
         if (fill_next[LINE_IDX_W] || last_byte) begin
            pend_in  = 1'b1;
            final_in = last_byte;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_BYTES; i++) begin
            line_ff[i] <= BYTE_PAD;
         end
         fill_ff    <= '0;
         lnum_ff    <= '0;
         wrapped_ff <= 1'b0;
         pend_ff    <= 1'b0;
         final_ff   <= 1'b0;
         red_ff     <= 1'b0;
         step_ff    <= 1'b0;
         rem_ff     <= '0;
         quo_ff     <= '0;
      end else begin
         line_ff    <= line_in;
         fill_ff    <= fill_in;
         lnum_ff    <= lnum_in;
         wrapped_ff <= wrapped_in;
         pend_ff    <= pend_in;
         final_ff   <= final_in;
         red_ff     <= red_in;
         step_ff    <= step_in;
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
      end
   end

endmodule

### hw/rtl/flpk_line_queue.sv
// Short line queue between the byte front end and the word emitter.
`timescale 1ns / 1ps
`include "flash_line_write_packer_core_defines.svh"
module flpk_line_queue #(
   parameter int DEPTH = flpk_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  flpk_pkg::line_entry_type push_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output flpk_pkg::line_entry_type pop_entry
);
   import flpk_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   line_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_fire, pop_fire;

   assign push_ready = count_ff != CNT_FULL;
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage, no reset needed
   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `FLPK_ASSERT_NEXT(a_count_up, clock, reset, push_fire && !pop_fire,
                     count_ff == $past(count_ff) + 1'b1)
   `FLPK_ASSERT_NEXT(a_count_down, clock, reset, pop_fire && !push_fire,
                     count_ff == $past(count_ff) - 1'b1)

endmodule

### hw/rtl/flpk_back.sv
// Back end: splits queued lines into four addressed 32-bit words.
`timescale 1ns / 1ps
`include "flash_line_write_packer_core_defines.svh"
module flpk_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   output logic                          head_pop,
   input  flpk_pkg::line_entry_type      head_entry,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [flpk_pkg::OFFSET_W-1:0] word_address,
   output logic [flpk_pkg::WORD_W-1:0]   word_data,
   output logic                          line_end,
   output logic                          write_end,
   output logic                          address_overflow
);
   import flpk_pkg::*;

   localparam logic [WORD_IDX_W-1:0] WORD_LAST = '1;

   logic [WORD_IDX_W-1:0] idx_ff;
   logic                  valid_ff;
   logic                  load;
   logic                  is_last_word;

   assign load         = head_valid && (!valid_ff || out_ready);
   assign is_last_word = idx_ff == WORD_LAST;
   assign head_pop     = load && is_last_word;
   assign out_valid    = valid_ff;

   // Word counter and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff   <= idx_ff + 1'b1;
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (load) begin
         word_address     <= {head_entry.line_addr, idx_ff, 2'b00};
         word_data        <= head_entry.line_data[{idx_ff, 5'b00000} +: WORD_W];
         line_end         <= is_last_word;
         write_end        <= is_last_word && head_entry.final_line;
         address_overflow <= head_entry.wrapped;
      end
   end

   `FLPK_ASSERT_NOW(a_mid_line_head, clock, reset, idx_ff != '0, head_valid)
   `FLPK_ASSERT_NOW(a_end_on_line_end, clock, reset, valid_ff && write_end, line_end)

endmodule

### hw/rtl/flash_line_write_packer_core.sv
// Flash line write packer top level: byte front end, line queue, word emitter.
// Path: a byte that closes a line passes the front end line register, a queue slot and the
//   word output register, after start line reduction when the start offset lies past flash end.
// Throughput: one byte per cycle while no start line reduction runs and no closed line
//   waits for queue space; each line leaves as four words, so short lines throttle the bytes.
// Reset (synchronous, active high): line cleared to 0xFF, offset and line zero, queue empty.
`timescale 1ns / 1ps
module flash_line_write_packer_core #(
   parameter int FLASH_PAGES = flpk_pkg::FLASH_PAGES_DEF,
   parameter int PAGE_BYTES  = flpk_pkg::PAGE_BYTES_DEF,
   parameter int QUEUE_DEPTH = flpk_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   flpk_req_if.sink   req_bus,
   flpk_rsp_if.source rsp_bus
);
   import flpk_pkg::*;

   logic           push_valid, push_ready;
   line_entry_type push_entry;
   logic           head_valid, head_pop;
   line_entry_type head_entry;

   flpk_front #(
      .FLASH_PAGES (FLASH_PAGES),
      .PAGE_BYTES  (PAGE_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_bus.valid),
      .in_ready     (req_bus.ready),
      .data_byte    (req_bus.data_byte),
      .start_offset (req_bus.start_offset),
      .first_byte   (req_bus.first_byte),
      .last_byte    (req_bus.last_byte),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_entry   (push_entry)
   );

   flpk_line_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (head_valid),
      .pop_ready  (head_pop),
      .pop_entry  (head_entry)
   );

   flpk_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_pop         (head_pop),
      .head_entry       (head_entry),
      .out_valid        (rsp_bus.valid),
      .out_ready        (rsp_bus.ready),
      .word_address     (rsp_bus.word_address),
      .word_data        (rsp_bus.word_data),
      .line_end         (rsp_bus.line_end),
      .write_end        (rsp_bus.write_end),
      .address_overflow (rsp_bus.address_overflow)
   );

endmodule
